[rtl/bmrc_pkg.sv]
// Shared types, constants and helpers of the bus monitor record classifier.
package bmrc_pkg;

    // Record word positions
    localparam logic [5:0] POS_HDR_FIRST = 6'd2;
    localparam logic [5:0] POS_HDR_LAST  = 6'd7;
    localparam logic [5:0] POS_CMD2      = 6'd9;
    localparam logic [5:0] POS_CMD1      = 6'd10;
    localparam logic [5:0] POS_WORD11    = 6'd11;
    localparam logic [5:0] POS_MAX       = 6'd63;

    // Filler pattern that marks an unused word pair
    localparam logic [15:0] FILLER = 16'hAA55;

    // Message classes
    localparam logic [1:0] CLS_RT_TO_CTRL = 2'd0;
    localparam logic [1:0] CLS_CTRL_TO_RT = 2'd1;
    localparam logic [1:0] CLS_RT_TO_RT   = 2'd2;
    localparam logic [1:0] CLS_VECTOR     = 2'd3;

    // Captured words of one record
    typedef struct packed {
        logic [5:0][15:0] hdr;    // words 2..7
        logic [15:0]      cmd2;   // word 9
        logic [15:0]      cmd1;   // word 10
        logic [15:0]      word11; // word 11
        logic [2:0][15:0] lrw;    // words 10, 11, 12 past the data length
    } record_t;

    // Decoded result of one record
    typedef struct packed {
        logic [1:0]  msg_class;
        logic [5:0]  data_length;
        logic [4:0]  rt_address;
        logic [3:0]  sub_address;
        logic [4:0]  rt_address_second;
        logic [3:0]  sub_address_second;
        logic [15:0] rt_status;
        logic [15:0] rt_status_second;
        logic [15:0] monitor_status;
        logic [15:0] bus_time;
        logic [31:0] system_time;
        logic [31:0] message_count;
    } result_t;

    // Record queue status
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_status_t;

    // Data word count of a command word, zero read as 32
    function automatic logic [5:0] cmd_length(input logic [15:0] cmd);
        logic [5:0] n;
        n = {1'b0, cmd[4:0]};
        return (n == 6'd0) ? 6'd32 : n;
    endfunction

endpackage

[rtl/bmrc_word_if.sv]
// Request channel that carries monitor record words.
interface bmrc_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic        last_word;

    modport source (output valid, output word, output last_word, input ready);
    modport sink   (input valid, input word, input last_word, output ready);
endinterface

[rtl/bmrc_result_if.sv]
// Request channel that carries decoded record results.
interface bmrc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  msg_class;
    logic [5:0]  data_length;
    logic [4:0]  rt_address;
    logic [3:0]  sub_address;
    logic [4:0]  rt_address_second;
    logic [3:0]  sub_address_second;
    logic [15:0] rt_status;
    logic [15:0] rt_status_second;
    logic [15:0] monitor_status;
    logic [15:0] bus_time;
    logic [31:0] system_time;
    logic [31:0] message_count;

    modport source (
        output valid, input ready,
        output msg_class, output data_length, output rt_address, output sub_address,
        output rt_address_second, output sub_address_second, output rt_status,
        output rt_status_second, output monitor_status, output bus_time,
        output system_time, output message_count
    );
    modport sink (
        input valid, output ready,
        input msg_class, input data_length, input rt_address, input sub_address,
        input rt_address_second, input sub_address_second, input rt_status,
        input rt_status_second, input monitor_status, input bus_time,
        input system_time, input message_count
    );
endinterface

[rtl/bmrc_front.sv]
// Front end: counts word positions, captures record words, queues finished records.
module bmrc_front (
    input  logic                clk,
    input  logic                rst_n,
    bmrc_word_if.sink           words,
    output logic                push_valid,
    input  logic                push_ready,
    output bmrc_pkg::record_t   push_rec
);

    logic [5:0]         pos_reg;
    logic [5:0]         pos_next;
    bmrc_pkg::record_t  rec_reg;
    bmrc_pkg::record_t  rec_next;
    bmrc_pkg::record_t  cap;
    logic [5:0]         len;
    logic [5:0]         base;
    logic               accept;

    // Take a word whenever the queue has room for a record
    assign words.ready = push_ready;
    assign accept      = words.valid && push_ready;

    // Capture the current word into its slot
    always_comb
    begin
        cap = rec_reg;
        if (pos_reg >= bmrc_pkg::POS_HDR_FIRST && pos_reg <= bmrc_pkg::POS_HDR_LAST)
        begin
            cap.hdr[3'(pos_reg - bmrc_pkg::POS_HDR_FIRST)] = words.word;
        end
        else if (pos_reg == bmrc_pkg::POS_CMD2)
        begin
            cap.cmd2 = words.word;
        end
        else if (pos_reg == bmrc_pkg::POS_CMD1)
        begin
            cap.cmd1 = words.word;
        end
        else if (pos_reg == bmrc_pkg::POS_WORD11)
        begin
            cap.word11 = words.word;
        end
        len  = bmrc_pkg::cmd_length(cap.cmd2);
        base = bmrc_pkg::POS_CMD1 + len;
        if (pos_reg >= base && pos_reg <= base + 6'd2)
        begin
            cap.lrw[2'(pos_reg - base)] = words.word;
        end
    end

    // Advance the position up to 63, or clear the record on its last word
    always_comb
    begin
        pos_next = pos_reg;
        rec_next = rec_reg;
        if (accept)
        begin
            if (words.last_word)
            begin
                pos_next = 6'd0;
                rec_next = '0;
            end
            else
            begin
                rec_next = cap;
                if (pos_reg != bmrc_pkg::POS_MAX)
                begin
                    pos_next = pos_reg + 6'd1;
                end
            end
        end
    end

    assign push_valid = accept && words.last_word;
    assign push_rec   = cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 6'd0;
            rec_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            rec_reg <= rec_next;
        end
    end

endmodule

[rtl/bmrc_queue.sv]
// Two-entry record queue between the front and back ends.
module bmrc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  bmrc_pkg::record_t     push_rec,
    input  logic                  pop,
    output bmrc_pkg::record_t     head_rec,
    output bmrc_pkg::q_status_t   status
);

    bmrc_pkg::record_t  mem_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic               do_pop;

    assign status.not_empty = (cnt_reg != 2'd0);
    assign status.not_full  = (cnt_reg != 2'd2);
    assign do_pop           = pop && status.not_empty;
    assign head_rec         = mem_reg[rd_ptr_reg];

    // Track the fill level
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push_valid && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push_valid && do_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Store records
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/bmrc_back.sv]
// Back end: classifies a queued record and holds the result in an output register.
module bmrc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmrc_pkg::record_t     head_rec,
    input  bmrc_pkg::q_status_t   status,
    output logic                  pop,
    bmrc_result_if.source         results
);

    bmrc_pkg::result_t  res_reg;
    bmrc_pkg::result_t  res_next;
    logic               valid_reg;
    logic               valid_next;
    logic               load;
    logic [1:0]         dir;
    logic [3:0]         sa9;
    logic               filler_pair;
    logic [1:0]         cls;

    // Load a new result when the register is empty or being taken
    assign load = !valid_reg || results.ready;
    assign pop  = load && status.not_empty;

    // Classify the record at the queue head
    always_comb
    begin
        dir = head_rec.cmd2[10:9];
        sa9 = head_rec.cmd2[8:5];
        filler_pair = (head_rec.lrw[1] == 16'd0 && head_rec.lrw[2] == 16'd0) ||
                      (head_rec.lrw[1] == bmrc_pkg::FILLER &&
                       head_rec.lrw[2] == bmrc_pkg::FILLER);
        if (dir == 2'd0)
        begin
            if (head_rec.cmd1[10:9] != 2'd0 && head_rec.cmd1[4:0] == head_rec.cmd2[4:0] &&
                !filler_pair)
            begin
                cls = bmrc_pkg::CLS_RT_TO_RT;
            end
            else
            begin
                cls = bmrc_pkg::CLS_CTRL_TO_RT;
            end
        end
        else
        begin
            cls = (sa9 == 4'd0) ? bmrc_pkg::CLS_VECTOR : bmrc_pkg::CLS_RT_TO_CTRL;
        end

        res_next.msg_class      = cls;
        res_next.data_length    = bmrc_pkg::cmd_length(head_rec.cmd2);
        res_next.monitor_status = head_rec.hdr[4];
        res_next.bus_time       = head_rec.hdr[5];
        res_next.system_time    = {head_rec.hdr[3], head_rec.hdr[2]};
        res_next.message_count  = {head_rec.hdr[1], head_rec.hdr[0]};
        if (cls == bmrc_pkg::CLS_RT_TO_RT)
        begin
            res_next.rt_address         = head_rec.cmd1[15:11];
            res_next.sub_address        = head_rec.cmd1[8:5];
            res_next.rt_address_second  = head_rec.cmd2[15:11];
            res_next.sub_address_second = sa9;
            res_next.rt_status          = head_rec.word11;
            res_next.rt_status_second   = head_rec.hdr[5];
        end
        else
        begin
            res_next.rt_address         = head_rec.cmd2[15:11];
            res_next.sub_address        = sa9;
            res_next.rt_address_second  = 5'd0;
            res_next.sub_address_second = 4'd0;
            res_next.rt_status          = (cls == bmrc_pkg::CLS_CTRL_TO_RT) ?
                                          head_rec.lrw[0] : head_rec.cmd1;
            res_next.rt_status_second   = 16'd0;
        end
    end

    assign valid_next = load ? status.not_empty : valid_reg;

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign results.valid              = valid_reg;
    assign results.msg_class          = res_reg.msg_class;
    assign results.data_length        = res_reg.data_length;
    assign results.rt_address         = res_reg.rt_address;
    assign results.sub_address        = res_reg.sub_address;
    assign results.rt_address_second  = res_reg.rt_address_second;
    assign results.sub_address_second = res_reg.sub_address_second;
    assign results.rt_status          = res_reg.rt_status;
    assign results.rt_status_second   = res_reg.rt_status_second;
    assign results.monitor_status     = res_reg.monitor_status;
    assign results.bus_time           = res_reg.bus_time;
    assign results.system_time        = res_reg.system_time;
    assign results.message_count      = res_reg.message_count;

endmodule

[rtl/bus_monitor_record_classifier_unit.sv]
// Top level of the bus monitor record classifier.
//
// Usage:
//   words   - request channel of 16-bit monitor record words; last_word
//             marks a record's last word; one is taken per cycle while ready.
//   results - one decoded request per record: message class, data length,
//             addresses, status words, times and message count.
//   A word is taken at a rising edge with valid and ready both high.
// A record's result reaches results via the record queue and then the output
//   register after its last word is taken; results.ready low holds it there.
//   Throughput: one word per cycle while words.ready is high, set by the
//   position counter and capture registers of the front end; one-word records
//   drain at one result per cycle while results.ready is high.
// Reset (rst_n low, asynchronous): the position counter and all captured
//   words clear to zero, the record queue empties, results.valid drops.
// Stall: when results.ready is low the result stays in the output register;
//   up to two further finished records wait in the queue, and words.ready
//   falls only once the queue is full.
module bus_monitor_record_classifier_unit (
    input  logic            clk,
    input  logic            rst_n,
    bmrc_word_if.sink       words,
    bmrc_result_if.source   results
);

    logic                   push_valid;
    bmrc_pkg::record_t      push_rec;
    bmrc_pkg::record_t      head_rec;
    bmrc_pkg::q_status_t    q_status;
    logic                   pop;

    bmrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (words),
        .push_valid (push_valid),
        .push_ready (q_status.not_full),
        .push_rec   (push_rec)
    );

    bmrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .pop        (pop),
        .head_rec   (head_rec),
        .status     (q_status)
    );

    bmrc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_rec (head_rec),
        .status   (q_status),
        .pop      (pop),
        .results  (results)
    );

    // The front never offers a record the queue cannot hold
    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> q_status.not_full)
        else $error("record pushed into a full queue");

    // A popped record always shows up as a result
    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> results.valid)
        else $error("popped record did not reach the output register");

    // Second-RT fields stay zero outside the RT-to-RT class
    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.msg_class != bmrc_pkg::CLS_RT_TO_RT) |->
        (results.rt_address_second == 5'd0 && results.sub_address_second == 4'd0 &&
         results.rt_status_second == 16'd0))
        else $error("second RT fields set outside RT-to-RT class");

endmodule
